// ===== rtl/ftc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftc_pkg - shared types and constants of the fuzzy transit classifier
// Item structs, configuration register indexes, rule byte encoding.
// ----------------------------------------------------------------------------
package ftc_pkg;

    typedef struct packed {
        logic [11:0] dip_depth;
        logic [11:0] dip_duration;
        logic [11:0] dip_interval;
    } candidate_t;

    typedef struct packed {
        logic [15:0] crisp_likelihood;
        logic        is_planet;
        logic [15:0] likely_strength;
        logic [15:0] unlikely_strength;
        logic        no_rule_fired;
    } verdict_t;

    // Combined rule strengths handed from the front to the back
    typedef struct packed {
        logic [15:0] likely;
        logic [15:0] unlikely;
    } strength_t;

    typedef enum logic [2:0] {
        CFG_RULES_LO   = 3'd0,
        CFG_RULES_MID  = 3'd1,
        CFG_RULES_HIGH = 3'd2,
        CFG_RULES_TOP  = 3'd3,
        CFG_THRESHOLD  = 3'd4,
        CFG_DIVISIONS  = 3'd5
    } cfg_index_t;

    localparam int RULE_WORDS      = 4;
    localparam int RULE_BITS       = RULE_WORDS * 64;
    localparam int RULE_LIKELY_BIT = 6;
    localparam int RULE_ENABLE_BIT = 7;

    localparam logic [1:0] TERM_UNUSED = 2'd0;
    localparam logic [1:0] TERM_LOW    = 2'd1;
    localparam logic [1:0] TERM_MID    = 2'd2;
    localparam logic [1:0] TERM_HIGH   = 2'd3;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    localparam logic [15:0] THRESHOLD_RESET = 16'd16384;
    localparam logic [12:0] DIVISIONS_RESET = 13'd1000;
    localparam logic [12:0] DIV_MIN         = 13'd2;
    localparam logic [12:0] DIV_MAX         = 13'd4096;

endpackage

// ===== rtl/ftc_fifo.sv =====
// ----------------------------------------------------------------------------
// ftc_fifo - small register queue
// Holds up to DEPTH items; DEPTH must be a power of two, which the block does not check.
// ----------------------------------------------------------------------------
module ftc_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign count_next = count_reg + CW'(do_push) - CW'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== rtl/ftc_front.sv =====
// ----------------------------------------------------------------------------
// ftc_front - fuzzification and rule evaluation
// Four stages: ramp numerators, constant division, rule minima, group maxima.
// ----------------------------------------------------------------------------
module ftc_front #(
    parameter int MAX_RULES = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  ftc_pkg::candidate_t          candidate,
    output logic                         full,
    input  logic [ftc_pkg::RULE_BITS-1:0] rules,
    output logic                         mid_push,
    output ftc_pkg::strength_t           mid_item,
    input  logic                         mid_full
);

    localparam int NG = (MAX_RULES + 7) / 8;
    localparam logic [23:0] RECIP_125 = 24'd8589935;
    localparam logic [16:0] RECIP_3   = 17'd87382;

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic [16:0] mid_y;
    } time_t;

    // Depth ramps: x/500 -> (8192n+62)/125, x/1000 -> (4096n+62)/125
    function automatic logic [22:0] depth_y(input logic [11:0] x, input logic [1:0] term);
        logic [9:0]  num;
        logic        wide;
        logic        zero;
        logic [22:0] y;
        num  = '0;
        wide = 1'b0;
        zero = 1'b1;
        unique case (term)
            ftc_pkg::TERM_LOW:
            begin
                if (x <= 12'd500)
                begin
                    num = x[9:0]; zero = 1'b0;
                end
                else if (x < 12'd1000)
                begin
                    num = 10'(12'd1000 - x); zero = 1'b0;
                end
            end
            ftc_pkg::TERM_MID:
            begin
                if (x > 12'd1500 && x < 12'd2000)
                begin
                    num = 10'(12'd2000 - x); zero = 1'b0;
                end
                else if (x > 12'd500 && x <= 12'd1500)
                begin
                    num = 10'(x - 12'd500); wide = 1'b1; zero = 1'b0;
                end
            end
            ftc_pkg::TERM_HIGH:
            begin
                if (x > 12'd1500 && x <= 12'd2500)
                begin
                    num = 10'(x - 12'd1500); wide = 1'b1; zero = 1'b0;
                end
                else if (x > 12'd2500 && x <= 12'd3000)
                begin
                    num = 10'(12'd3000 - x); zero = 1'b0;
                end
            end
            default: ;
        endcase
        if (zero)
            y = '0;
        else if (wide)
            y = {1'b0, num, 12'd0} + 23'd62;
        else
            y = {num, 13'd0} + 23'd62;
        return y;
    endfunction

    // Time ramps: 1/256 spans are shifts, the 384 span is (256n+1)/3
    function automatic time_t time_pieces(input logic [11:0] x);
        time_t r;
        logic [8:0] num;
        r   = '0;
        num = '0;
        if (x <= 12'd256)
            r.lo = {x[8:0], 7'd0};
        else if (x < 12'd512)
            r.lo = {9'(12'd512 - x), 7'd0};
        if (x >= 12'd1024 && x <= 12'd1280)
            r.hi = {9'(x - 12'd1024), 7'd0};
        else if (x > 12'd1280 && x <= 12'd1536)
            r.hi = {9'(12'd1536 - x), 7'd0};
        if (x >= 12'd384 && x <= 12'd768)
        begin
            num     = 9'(x - 12'd384);
            r.mid_y = {num, 8'd1};
        end
        else if (x > 12'd768 && x < 12'd1152)
        begin
            num     = 9'(12'd1152 - x);
            r.mid_y = {num, 8'd1};
        end
        return r;
    endfunction

    function automatic logic [15:0] div125(input logic [22:0] y);
        logic [46:0] p;
        p = 47'(y) * 47'(RECIP_125);
        return p[45:30];
    endfunction

    function automatic logic [15:0] div3(input logic [16:0] y);
        logic [33:0] p;
        p = 34'(y) * 34'(RECIP_3);
        return p[33:18];
    endfunction

    function automatic logic [15:0] pick(input logic [1:0] code, input logic [15:0] m1,
                                         input logic [15:0] m2, input logic [15:0] m3);
        logic [15:0] r;
        unique case (code)
            ftc_pkg::TERM_UNUSED: r = ftc_pkg::ONE_Q15;
            ftc_pkg::TERM_LOW:    r = m1;
            ftc_pkg::TERM_MID:    r = m2;
            ftc_pkg::TERM_HIGH:   r = m3;
            default:              r = ftc_pkg::ONE_Q15;
        endcase
        return r;
    endfunction

    logic  adv;
    logic  v1_reg, v2_reg, v3_reg, v4_reg;

    logic [22:0] dy_reg [1:3];
    time_t       tu_reg, ti_reg;
    logic [15:0] md_reg [1:3];
    logic [15:0] mu_reg [1:3];
    logic [15:0] mi_reg [1:3];
    logic [15:0] str_reg [MAX_RULES];
    logic        cls_reg [MAX_RULES];
    logic [15:0] gl_reg [NG];
    logic [15:0] gu_reg [NG];

    logic [15:0] str_next [MAX_RULES];
    logic        cls_next [MAX_RULES];
    logic [15:0] gl_next [NG];
    logic [15:0] gu_next [NG];
    logic [15:0] likely_max, unlikely_max;

    // Stall the whole front when its last stage cannot hand over
    assign adv      = !(v4_reg && mid_full);
    assign full     = !adv;
    assign mid_push = v4_reg && !mid_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        logic [7:0]  b;
        logic [15:0] a0, a1, a2, s;
        for (int k = 0; k < MAX_RULES; k++)
        begin
            b  = rules[8*k +: 8];
            a0 = pick(b[1:0], md_reg[1], md_reg[2], md_reg[3]);
            a1 = pick(b[3:2], mu_reg[1], mu_reg[2], mu_reg[3]);
            a2 = pick(b[5:4], mi_reg[1], mi_reg[2], mi_reg[3]);
            s  = (a0 < a1) ? a0 : a1;
            s  = (s < a2) ? s : a2;
            str_next[k] = b[ftc_pkg::RULE_ENABLE_BIT] ? s : 16'd0;
            cls_next[k] = b[ftc_pkg::RULE_LIKELY_BIT];
        end
    end

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            gl_next[g] = '0;
            gu_next[g] = '0;
            for (int j = 0; j < 8; j++)
            begin
                if (8*g + j < MAX_RULES)
                begin
                    if (cls_reg[8*g+j])
                    begin
                        if (str_reg[8*g+j] > gl_next[g])
                            gl_next[g] = str_reg[8*g+j];
                    end
                    else if (str_reg[8*g+j] > gu_next[g])
                        gu_next[g] = str_reg[8*g+j];
                end
            end
        end
    end

    always_comb
    begin
        likely_max   = '0;
        unlikely_max = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (gl_reg[g] > likely_max)
                likely_max = gl_reg[g];
            if (gu_reg[g] > unlikely_max)
                unlikely_max = gu_reg[g];
        end
    end

    assign mid_item.likely   = likely_max;
    assign mid_item.unlikely = unlikely_max;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int t = 1; t <= 3; t++)
            begin
                dy_reg[t] <= depth_y(candidate.dip_depth, 2'(t));
                md_reg[t] <= div125(dy_reg[t]);
            end
            tu_reg    <= time_pieces(candidate.dip_duration);
            ti_reg    <= time_pieces(candidate.dip_interval);
            mu_reg[1] <= tu_reg.lo;
            mu_reg[2] <= div3(tu_reg.mid_y);
            mu_reg[3] <= tu_reg.hi;
            mi_reg[1] <= ti_reg.lo;
            mi_reg[2] <= div3(ti_reg.mid_y);
            mi_reg[3] <= ti_reg.hi;
            for (int k = 0; k < MAX_RULES; k++)
            begin
                str_reg[k] <= str_next[k];
                cls_reg[k] <= cls_next[k];
            end
            for (int g = 0; g < NG; g++)
            begin
                gl_reg[g] <= gl_next[g];
                gu_reg[g] <= gu_next[g];
            end
        end
    end

endmodule

// ===== rtl/ftc_back.sv =====
// ----------------------------------------------------------------------------
// ftc_back - closed-form centroid and decision
// Weight products, sums, denominator, then a 16-stage restoring divider.
// ----------------------------------------------------------------------------
module ftc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mid_empty,
    input  ftc_pkg::strength_t mid_item,
    output logic               mid_pop,
    input  logic [15:0]        threshold,
    input  logic [12:0]        divisions,
    output logic               out_push,
    output ftc_pkg::verdict_t  out_item,
    input  logic               out_full
);

    localparam int QW = 16;
    localparam int RW = 58;
    localparam int DW = 43;

    // Divisions-derived constants, recomputed whenever the register changes
    logic [12:0] n_reg, n_next;
    logic [11:0] h1_reg, nh_reg;
    logic [22:0] plo_reg;
    logic [25:0] pall_reg;
    logic [21:0] slo_reg;
    logic [23:0] shi_reg;
    logic [11:0] h;

    always_comb
    begin
        if (divisions < ftc_pkg::DIV_MIN)
            n_next = ftc_pkg::DIV_MIN;
        else if (divisions > ftc_pkg::DIV_MAX)
            n_next = ftc_pkg::DIV_MAX;
        else
            n_next = divisions;
        h = n_next[12:1];
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        h1_reg   <= h + 12'd1;
        nh_reg   <= 12'(n_next - {1'b0, h});
        plo_reg  <= 23'({11'd0, h} * (23'(h) + 23'd1));
        pall_reg <= 26'({13'd0, n_next} * (26'(n_next) + 26'd1));
        slo_reg  <= plo_reg[22:1];
        shi_reg  <= 24'(pall_reg[25:1] - 25'(plo_reg[22:1]));
    end

    logic adv;
    logic b1v_reg, b2v_reg, b3v_reg;
    logic [15:0] b1u_reg, b1l_reg, b2u_reg, b2l_reg, b3u_reg, b3l_reg;
    logic [27:0] pa_reg, pb_reg;
    logic [37:0] pc_reg;
    logic [39:0] pd_reg;
    logic [28:0] wsum_reg;
    logic [40:0] num_reg, b3num_reg;
    logic [41:0] den_reg;
    logic        b3none_reg;

    // Divider stages: index 0 prepares, 1..QW each settle one quotient bit
    logic          dv_reg   [0:QW];
    logic [RW-1:0] rem_reg  [0:QW];
    logic [DW-1:0] dd_reg   [0:QW];
    logic [QW-1:0] q_reg    [0:QW];
    logic [15:0]   du_reg   [0:QW];
    logic [15:0]   dl_reg   [0:QW];
    logic          dn_reg   [0:QW];

    logic [15:0] crisp;

    assign adv      = !(dv_reg[QW] && out_full);
    assign mid_pop  = adv && !mid_empty;
    assign out_push = dv_reg[QW] && !out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1v_reg <= 1'b0;
            b2v_reg <= 1'b0;
            b3v_reg <= 1'b0;
            for (int k = 0; k <= QW; k++)
                dv_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            b1v_reg   <= !mid_empty;
            b2v_reg   <= b1v_reg;
            b3v_reg   <= b2v_reg;
            dv_reg[0] <= b3v_reg;
            for (int k = 1; k <= QW; k++)
                dv_reg[k] <= dv_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1u_reg   <= mid_item.unlikely;
            b1l_reg   <= mid_item.likely;
            pa_reg    <= 28'(mid_item.unlikely) * 28'(h1_reg);
            pb_reg    <= 28'(mid_item.likely) * 28'(nh_reg);
            pc_reg    <= 38'(mid_item.unlikely) * 38'(slo_reg);
            pd_reg    <= 40'(mid_item.likely) * 40'(shi_reg);

            b2u_reg   <= b1u_reg;
            b2l_reg   <= b1l_reg;
            wsum_reg  <= 29'(pa_reg) + 29'(pb_reg);
            num_reg   <= 41'(pc_reg) + 41'(pd_reg);

            b3u_reg    <= b2u_reg;
            b3l_reg    <= b2l_reg;
            den_reg    <= 42'(wsum_reg) * 42'(n_reg);
            b3num_reg  <= num_reg;
            b3none_reg <= (wsum_reg == '0);

            // Round half up: (2*num*32768 + den) / (2*den)
            rem_reg[0] <= {1'b0, b3num_reg, 16'd0} + RW'(den_reg);
            dd_reg[0]  <= {den_reg, 1'b0};
            q_reg[0]   <= '0;
            du_reg[0]  <= b3u_reg;
            dl_reg[0]  <= b3l_reg;
            dn_reg[0]  <= b3none_reg;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        logic [RW-1:0] shifted;
        logic          fits;
        assign shifted = RW'(dd_reg[k-1]) << (QW - k);
        assign fits    = (rem_reg[k-1] >= shifted);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= fits ? rem_reg[k-1] - shifted : rem_reg[k-1];
                dd_reg[k]  <= dd_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][QW-2:0], fits};
                du_reg[k]  <= du_reg[k-1];
                dl_reg[k]  <= dl_reg[k-1];
                dn_reg[k]  <= dn_reg[k-1];
            end
        end
    end

    assign crisp = dn_reg[QW] ? 16'd0 : q_reg[QW];

    assign out_item.crisp_likelihood  = crisp;
    assign out_item.is_planet         = (crisp > threshold);
    assign out_item.likely_strength   = dl_reg[QW];
    assign out_item.unlikely_strength = du_reg[QW];
    assign out_item.no_rule_fired     = dn_reg[QW];

endmodule

// ===== rtl/fuzzy_transit_classifier.sv =====
// ----------------------------------------------------------------------------
// fuzzy_transit_classifier - fuzzy planet/non-planet verdict for transits
// Usage:
//   Input channel: drive candidate and raise push; the item is taken at a
//   clock edge where push is high and full is low.
//   Result channel: while empty is low the oldest verdict sits on verdict;
//   raise pop to take it.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//   is always high. Write only while no item is in flight.
//   Throughput: one item per cycle, sustained, as long as results are popped.
//   Path from push to empty dropping on an idle block: four front stages,
//   the middle queue, three arithmetic stages, one prepare stage and
//   sixteen divider stages (one quotient bit each), then the out queue.
//   Reset: queues flush, rule words clear to zero, threshold goes to 0.5,
//   divisions to 1000.
//   Receiver stall: the back pipeline holds once the out queue fills, the
//   middle queue then fills, and finally the front holds and raises full.
// ----------------------------------------------------------------------------
module fuzzy_transit_classifier #(
    parameter int MAX_RULES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ftc_pkg::candidate_t candidate,
    output logic                full,
    input  logic                pop,
    output ftc_pkg::verdict_t   verdict,
    output logic                empty,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    logic [63:0] rules_lo_reg, rules_mid_reg, rules_high_reg, rules_top_reg;
    logic [15:0] threshold_reg;
    logic [12:0] divisions_reg;
    logic [ftc_pkg::RULE_BITS-1:0] rules;

    // Front to back hand-off
    logic               mid_push, mid_full, mid_pop, mid_empty;
    ftc_pkg::strength_t mid_in, mid_out;

    // Back to result queue
    logic               out_push, out_full;
    ftc_pkg::verdict_t  out_item;

    assign cfg_ready = 1'b1;
    assign rules = {rules_top_reg, rules_high_reg, rules_mid_reg, rules_lo_reg};

    // Register writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_lo_reg   <= '0;
            rules_mid_reg  <= '0;
            rules_high_reg <= '0;
            rules_top_reg  <= '0;
            threshold_reg  <= ftc_pkg::THRESHOLD_RESET;
            divisions_reg  <= ftc_pkg::DIVISIONS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ftc_pkg::CFG_RULES_LO:   rules_lo_reg   <= cfg_data;
                ftc_pkg::CFG_RULES_MID:  rules_mid_reg  <= cfg_data;
                ftc_pkg::CFG_RULES_HIGH: rules_high_reg <= cfg_data;
                ftc_pkg::CFG_RULES_TOP:  rules_top_reg  <= cfg_data;
                ftc_pkg::CFG_THRESHOLD:  threshold_reg  <= cfg_data[15:0];
                ftc_pkg::CFG_DIVISIONS:  divisions_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Fuzzify and fire rules
    ftc_front #(
        .MAX_RULES (MAX_RULES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .candidate (candidate),
        .full      (full),
        .rules     (rules),
        .mid_push  (mid_push),
        .mid_item  (mid_in),
        .mid_full  (mid_full)
    );

    // Decouple the front from the back so each can stall on its own
    ftc_fifo #(
        .DEPTH (4),
        .WIDTH ($bits(ftc_pkg::strength_t))
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_in),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_out),
        .empty (mid_empty)
    );

    // Centroid, divide and decide
    ftc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (mid_out),
        .mid_pop   (mid_pop),
        .threshold (threshold_reg),
        .divisions (divisions_reg),
        .out_push  (out_push),
        .out_item  (out_item),
        .out_full  (out_full)
    );

    // Result queue; holds finished items while the receiver stalls
    ftc_fifo #(
        .DEPTH (2),
        .WIDTH ($bits(ftc_pkg::verdict_t))
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (verdict),
        .empty (empty)
    );

endmodule
